// ----- hdl/mvna_pkg.sv -----
// Shared types and constants for the mesh vertex normal accumulator.
package mvna_pkg;

  localparam int VERTEX_DEPTH_DEF = 1024;
  localparam int SUM_WIDTH_DEF    = 24;
  localparam int IDX_W            = 10;
  localparam int POS_W            = 32;
  localparam int NORM_W           = 16;
  localparam int ONE_Q14          = 16384;
  localparam int Q_DEPTH          = 4;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_TRI   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_FLAG  = 3'd1,
    OP_WRITE = 3'd2,
    OP_TRI   = 3'd3,
    OP_QUERY = 3'd4
  } op_code_t;

  typedef struct packed {
    op_code_t                 op;
    logic [IDX_W-1:0]         a;
    logic [IDX_W-1:0]         b;
    logic [IDX_W-1:0]         c;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [POS_W-1:0]  z;
  } op_t;

  typedef struct packed {
    logic push;
    op_t  item;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- hdl/mvna_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mvna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/mvna_front.sv -----
// Front end: accept requests, range check indices and classify into queue ops.
module mvna_front #(
  parameter int VERTEX_DEPTH = mvna_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [127:0]           s_tdata,
  input  logic [1:0]             s_tuser,
  input  logic                   clearing,
  input  mvna_pkg::fifo_stat_t   stat,
  output mvna_pkg::q_wr_t        wr
);
  import mvna_pkg::*;

  logic ok_a, ok_b, ok_c;
  op_t  item;

  assign ok_a = 32'(s_tdata[9:0])   < VERTEX_DEPTH;
  assign ok_b = 32'(s_tdata[19:10]) < VERTEX_DEPTH;
  assign ok_c = 32'(s_tdata[29:20]) < VERTEX_DEPTH;

  always_comb begin
    item.a = s_tdata[9:0];
    item.b = s_tdata[19:10];
    item.c = s_tdata[29:20];
    item.x = s_tdata[61:30];
    item.y = s_tdata[93:62];
    item.z = s_tdata[125:94];
    case (kind_t'(s_tuser))
      KIND_WRITE: item.op = ok_a ? OP_WRITE : OP_NOP;
      KIND_TRI:   item.op = (ok_a && ok_b && ok_c) ? OP_TRI : OP_FLAG;
      KIND_QUERY: item.op = ok_a ? OP_QUERY : OP_FLAG;
      default:    item.op = OP_NOP;
    endcase
  end

  // Hold off while the queue is full or the sum store is still being cleared.
  assign s_tready = !stat.full && !clearing;
  assign wr.push  = s_tvalid && s_tready;
  assign wr.item  = item;
endmodule

// ----- hdl/mvna_fifo.sv -----
// Short op queue between the front end and the back end.
module mvna_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  mvna_pkg::q_wr_t      wr,
  input  logic                 pop,
  output mvna_pkg::op_t        head,
  output mvna_pkg::fifo_stat_t stat
);
  import mvna_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  op_t             mem [Q_DEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [PW:0]     count;

  assign head       = mem[rptr];
  assign stat.full  = count == (PW + 1)'(Q_DEPTH);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wptr] <= wr.item;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr.push) begin
        wptr <= (wptr == PW'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW + 1)'(wr.push) - (PW + 1)'(pop);
    end
  end
endmodule

// ----- hdl/mvna_back.sv -----
// Back end: sequencer with stores, shared multiplier, square root and divider.
module mvna_back #(
  parameter int VERTEX_DEPTH = mvna_pkg::VERTEX_DEPTH_DEF,
  parameter int SUM_WIDTH    = mvna_pkg::SUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mvna_pkg::fifo_stat_t stat,
  input  mvna_pkg::op_t        head,
  output logic                 pop,
  output logic                 clearing,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,
  output logic [0:0]           m_tuser
);
  import mvna_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);
  localparam int SW = SUM_WIDTH;
  localparam logic signed [SW:0] SAT_HI = {2'b00, {(SW-1){1'b1}}};
  localparam logic signed [SW:0] SAT_LO = {2'b11, {(SW-1){1'b0}}};

  typedef enum logic [19:0] {
    S_CLEAR  = 20'h00001,
    S_IDLE   = 20'h00002,
    S_RD_A   = 20'h00004,
    S_RD_B   = 20'h00008,
    S_RD_C   = 20'h00010,
    S_EDGE   = 20'h00020,
    S_FIT    = 20'h00040,
    S_MUL    = 20'h00080,
    S_QRD    = 20'h00100,
    S_QLD    = 20'h00200,
    S_NMAG   = 20'h00400,
    S_NSHIFT = 20'h00800,
    S_SQ     = 20'h01000,
    S_SQRT   = 20'h02000,
    S_DSET   = 20'h04000,
    S_DIV    = 20'h08000,
    S_NDONE  = 20'h10000,
    S_RMW_RD = 20'h20000,
    S_RMW_WR = 20'h40000,
    S_OUT    = 20'h80000
  } state_t;

  state_t                  state;
  op_t                     cur;
  logic [AW-1:0]           clr_cnt;
  logic signed [POS_W-1:0] pa [3];
  logic signed [POS_W-1:0] pb [3];
  logic signed [POS_W:0]   e1 [3];
  logic signed [POS_W:0]   e2 [3];
  logic [2:0]              cnt;
  logic signed [POS_W-1:0] mul_a, mul_b;
  logic signed [63:0]      mul_p;
  logic signed [63:0]      cr [3];
  logic [2:0]              neg;
  logic [63:0]             m [3];
  logic [63:0]             mx;
  logic [63:0]             s, res, bitv, sq_t;
  logic                    sq_ge;
  logic [15:0]             dnum;
  logic [44:0]             dnum_w;
  logic [32:0]             drem, dt;
  logic                    dge;
  logic [15:0]             dq, qf, qc;
  logic [3:0]              dcnt;
  logic [1:0]              ci, rk;
  logic signed [NORM_W-1:0] fn [3];
  logic                    res_degen;
  logic                    fit1, fit2;
  logic [IDX_W-1:0]        corner;

  logic                    pos_we;
  logic [AW-1:0]           pos_waddr, pos_raddr;
  logic [3*POS_W-1:0]      pos_wdata, pos_rdata;
  logic                    sum_we;
  logic [AW-1:0]           sum_waddr, sum_raddr;
  logic [3*SW-1:0]         sum_wdata, sum_rdata, sum_sat;

  function automatic logic too_big(input logic signed [POS_W:0] v);
    return (v > $signed({2'b00, {(POS_W-1){1'b1}}})) ||
           (v < $signed({2'b11, {(POS_W-2){1'b0}}, 1'b1}));
  endfunction

  mvna_ram #(.WIDTH(3*POS_W), .DEPTH(VERTEX_DEPTH)) u_pos (
    .clk, .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  mvna_ram #(.WIDTH(3*SW), .DEPTH(VERTEX_DEPTH)) u_sum (
    .clk, .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  assign pop      = (state == S_IDLE) && !stat.empty;
  assign clearing = state == S_CLEAR;

  always_comb begin
    case (rk)
      2'd0:    corner = cur.a;
      2'd1:    corner = cur.b;
      default: corner = cur.c;
    endcase
  end

  // Store ports.
  always_comb begin
    pos_we    = pop && (head.op == OP_WRITE);
    pos_waddr = AW'(head.a);
    pos_wdata = {head.z, head.y, head.x};
    case (state)
      S_RD_B:  pos_raddr = AW'(cur.b);
      S_RD_C:  pos_raddr = AW'(cur.c);
      default: pos_raddr = AW'(cur.a);
    endcase
    sum_raddr = (state == S_RMW_RD) ? AW'(corner) : AW'(cur.a);
    sum_we    = 1'b0;
    sum_waddr = AW'(corner);
    sum_wdata = '0;
    if (state == S_CLEAR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_cnt;
    end else if (pos_we) begin
      sum_we    = 1'b1;
      sum_waddr = AW'(head.a);
    end else if (state == S_RMW_WR) begin
      sum_we    = 1'b1;
      sum_wdata = sum_sat;
    end
  end

  // Saturating add of the triangle normal onto the sum just read.
  always_comb begin
    logic signed [SW:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = (SW + 1)'($signed(sum_rdata[i*SW +: SW])) + (SW + 1)'(fn[i]);
      if (acc > SAT_HI) begin
        acc = SAT_HI;
      end else if (acc < SAT_LO) begin
        acc = SAT_LO;
      end
      sum_sat[i*SW +: SW] = acc[SW-1:0];
    end
  end

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL) begin
      case (cnt)
        3'd0:    begin mul_a = POS_W'(e1[1]); mul_b = POS_W'(e2[2]); end
        3'd1:    begin mul_a = POS_W'(e1[2]); mul_b = POS_W'(e2[1]); end
        3'd2:    begin mul_a = POS_W'(e1[2]); mul_b = POS_W'(e2[0]); end
        3'd3:    begin mul_a = POS_W'(e1[0]); mul_b = POS_W'(e2[2]); end
        3'd4:    begin mul_a = POS_W'(e1[0]); mul_b = POS_W'(e2[1]); end
        3'd5:    begin mul_a = POS_W'(e1[1]); mul_b = POS_W'(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == S_SQ) begin
      case (cnt)
        3'd0:    begin mul_a = POS_W'(m[0]); mul_b = POS_W'(m[0]); end
        3'd1:    begin mul_a = POS_W'(m[1]); mul_b = POS_W'(m[1]); end
        3'd2:    begin mul_a = POS_W'(m[2]); mul_b = POS_W'(m[2]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_comb begin
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    fit1   = too_big(e1[0]) || too_big(e1[1]) || too_big(e1[2]);
    fit2   = too_big(e2[0]) || too_big(e2[1]) || too_big(e2[2]);
    sq_t   = res + bitv;
    sq_ge  = s >= sq_t;
    dnum_w = {1'b0, m[ci][29:0], 14'd0} + 45'(res[31:1]);
    dt     = {drem[31:0], dnum[dcnt]};
    dge    = dt >= {1'b0, res[31:0]};
    qf     = {dq[14:0], dge};
    qc     = (qf > 16'(ONE_Q14)) ? 16'(ONE_Q14) : qf;
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(VERTEX_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur       <= head;
            res_degen <= head.op == OP_FLAG;
            rk        <= '0;
            for (int i = 0; i < 3; i++) fn[i] <= '0;
            case (head.op)
              OP_TRI:   state <= S_RD_A;
              OP_QUERY: state <= S_QRD;
              default:  state <= S_OUT;
            endcase
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          for (int i = 0; i < 3; i++) pa[i] <= pos_rdata[i*POS_W +: POS_W];
          state <= S_RD_C;
        end
        S_RD_C: begin
          for (int i = 0; i < 3; i++) pb[i] <= pos_rdata[i*POS_W +: POS_W];
          state <= S_EDGE;
        end
        S_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= {pb[i][POS_W-1], pb[i]} - {pa[i][POS_W-1], pa[i]};
            e2[i] <= $signed({pos_rdata[i*POS_W + POS_W - 1], pos_rdata[i*POS_W +: POS_W]})
                     - {pa[i][POS_W-1], pa[i]};
          end
          state <= S_FIT;
        end
        S_FIT: begin
          // Halve an oversized edge; direction of the normal is kept.
          if (fit1) begin
            for (int i = 0; i < 3; i++) e1[i] <= e1[i] >>> 1;
          end
          if (fit2) begin
            for (int i = 0; i < 3; i++) e2[i] <= e2[i] >>> 1;
          end
          if (!fit1 && !fit2) begin
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          case (cnt)
            3'd1:    cr[0] <= mul_p;
            3'd2:    cr[0] <= cr[0] - mul_p;
            3'd3:    cr[1] <= mul_p;
            3'd4:    cr[1] <= cr[1] - mul_p;
            3'd5:    cr[2] <= mul_p;
            3'd6:    begin cr[2] <= cr[2] - mul_p; state <= S_NMAG; end
            default: ;
          endcase
        end
        S_QRD: state <= S_QLD;
        S_QLD: begin
          for (int i = 0; i < 3; i++) cr[i] <= 64'($signed(sum_rdata[i*SW +: SW]));
          state <= S_NMAG;
        end
        S_NMAG: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= cr[i][63];
            m[i]   <= cr[i][63] ? 64'(-cr[i]) : 64'(cr[i]);
          end
          if (cr[0] == '0 && cr[1] == '0 && cr[2] == '0) begin
            res_degen <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_NSHIFT;
          end
        end
        S_NSHIFT: begin
          // Bring the largest magnitude into [2^29, 2^30).
          if (mx >= (64'd1 << 34)) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 4;
          end else if (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (mx < (64'd1 << 25)) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 4;
          end else if (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          cnt <= cnt + 1'b1;
          case (cnt)
            3'd1:    s <= 64'(mul_p);
            3'd2:    s <= s + 64'(mul_p);
            3'd3:    begin
              s     <= s + 64'(mul_p);
              res   <= '0;
              bitv  <= 64'd1 << 62;
              state <= S_SQRT;
            end
            default: ;
          endcase
        end
        S_SQRT: begin
          if (sq_ge) begin
            s   <= s - sq_t;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv == 64'd1) begin
            ci    <= '0;
            state <= S_DSET;
          end
        end
        S_DSET: begin
          dnum  <= dnum_w[15:0];
          drem  <= 33'(dnum_w[44:16]);
          dq    <= '0;
          dcnt  <= 4'd15;
          state <= S_DIV;
        end
        S_DIV: begin
          drem <= dge ? dt - {1'b0, res[31:0]} : dt;
          dq   <= qf;
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            fn[ci] <= neg[ci] ? -NORM_W'(qc) : NORM_W'(qc);
            if (ci == 2'd2) begin
              state <= S_NDONE;
            end else begin
              ci    <= ci + 1'b1;
              state <= S_DSET;
            end
          end
        end
        S_NDONE: state <= (cur.op == OP_TRI) ? S_RMW_RD : S_OUT;
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: begin
          rk <= rk + 1'b1;
          state <= (rk == 2'd2) ? S_OUT : S_RMW_RD;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= (cur.op == OP_QUERY) ? {fn[2], fn[1], fn[0]} : '0;
            m_tuser  <= res_degen;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/mesh_vertex_normal_accumulator_unit.sv -----
// Top level of the mesh vertex normal accumulator.
// Flow: a vertex write, a flagged request or a dropped one goes from the queue straight
//   to the output state; a triangle or a query runs on through the arithmetic (a zero
//   cross product or a zero sum ends early), through the bit-serial square root (32 steps)
//   and the restoring divider that both share.
// Throughput: one request at a time in the back end; up to four wait in the queue.
// Reset: synchronous; afterwards a clearing pass writes every normal sum to zero,
//   during which s_tready stays low.
module mesh_vertex_normal_accumulator_unit #(
  parameter int VERTEX_DEPTH = mvna_pkg::VERTEX_DEPTH_DEF,
  parameter int SUM_WIDTH    = mvna_pkg::SUM_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vert_a, vert_b, vert_c, pos_x, pos_y, pos_z, two zero pad bits
  input  logic [127:0] s_tdata,
  // kind
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // norm_x, norm_y, norm_z
  output logic [47:0]  m_tdata,
  // degenerate
  output logic [0:0]   m_tuser
);
  import mvna_pkg::*;

  q_wr_t      wr;
  fifo_stat_t stat;
  op_t        head;
  logic       pop;
  logic       clearing;

  // Classify each request and drop it into the queue.
  mvna_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .clearing, .stat, .wr
  );

  // Hold queued ops so the front can keep accepting while the back works.
  mvna_fifo u_fifo (
    .clk, .rst, .wr, .pop, .head, .stat
  );

  // Advance one op at a time through the stores and the arithmetic.
  mvna_back #(.VERTEX_DEPTH(VERTEX_DEPTH), .SUM_WIDTH(SUM_WIDTH)) u_back (
    .clk, .rst, .stat, .head, .pop, .clearing,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );
endmodule

// ----- hdl/mvna_checker.sv -----
// Port-level checks for the mesh vertex normal accumulator, bound to the top level.
module mvna_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [127:0] s_tdata,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [47:0]  m_tdata,
  input logic [0:0]   m_tuser
);
  // The clearing pass blocks input right after reset.
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("input accepted or result shown during clearing");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 48'd0)
    else $error("flagged result carries a normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384) &&
                 ($signed(m_tdata[15:0]) >= -16'sd16384) &&
                 ($signed(m_tdata[31:16]) <= 16'sd16384) &&
                 ($signed(m_tdata[31:16]) >= -16'sd16384) &&
                 ($signed(m_tdata[47:32]) <= 16'sd16384) &&
                 ($signed(m_tdata[47:32]) >= -16'sd16384))
    else $error("normal component out of Q1.14 range");
endmodule

bind mesh_vertex_normal_accumulator_unit mvna_checker u_mvna_checker (.*);

// ----- tb/mvna_scoreboard.sv -----
// Predicts and checks the results of the mesh vertex normal accumulator.
`timescale 1ns / 1ps
module mvna_scoreboard (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [47:0]  m_tdata,
  input  logic [0:0]   m_tuser,
  output int           errors,
  output int           pending,
  output int           n_results,
  output int           n_flagged
);
  import mvna_pkg::*;

  localparam longint SUM_HI = (64'sd1 <<< (SUM_WIDTH_DEF - 1)) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< (SUM_WIDTH_DEF - 1));

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     degen;
  } normal_res_t;

  longint vpos [VERTEX_DEPTH_DEF][3];
  longint nsum [VERTEX_DEPTH_DEF][3];
  normal_res_t expected_normals[$];

  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint half_floor(longint v);
    return v >>> 1;
  endfunction

  function automatic longint root_floor(longint s);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > s) b = b >>> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Scale the vector to a fixed magnitude band, then divide by its length.
  function automatic bit unit_q14(input longint v[3], output longint o[3]);
    longint m[3];
    longint mx, len, q;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(v[i]);
      o[i] = 0;
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx == 0) return 0;
    while (mx >= (64'sd1 <<< 30)) begin
      mx = mx >>> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
    end
    while (mx < (64'sd1 <<< 29)) begin
      mx = mx <<< 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] <<< 1;
    end
    len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] <<< 14) + (len >>> 1)) / len;
      if (q > ONE_Q14) q = ONE_Q14;
      o[i] = v[i] < 0 ? -q : q;
    end
    return 1;
  endfunction

  function automatic void shrink_edge(ref longint e[3]);
    for (int g = 0; g < 8; g++) begin
      if (mag64(e[0]) <= 64'sd2147483647 && mag64(e[1]) <= 64'sd2147483647 &&
          mag64(e[2]) <= 64'sd2147483647) return;
      for (int i = 0; i < 3; i++) e[i] = half_floor(e[i]);
    end
  endfunction

  function automatic longint clamp_sum(longint a, longint b);
    longint r;
    r = a + b;
    if (r > SUM_HI) r = SUM_HI;
    if (r < SUM_LO) r = SUM_LO;
    return r;
  endfunction

  function automatic normal_res_t predict_normal(logic [1:0] kind, logic [127:0] d);
    normal_res_t r;
    int ia, ib, ic;
    longint e1[3], e2[3], cr[3], fn[3], nv[3];
    ia = int'(d[9:0]);
    ib = int'(d[19:10]);
    ic = int'(d[29:20]);
    r = '0;
    nv = '{0, 0, 0};
    case (kind)
      KIND_WRITE: begin
        vpos[ia][0] = longint'($signed(d[61:30]));
        vpos[ia][1] = longint'($signed(d[93:62]));
        vpos[ia][2] = longint'($signed(d[125:94]));
        for (int i = 0; i < 3; i++) nsum[ia][i] = 0;
      end
      KIND_TRI: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = vpos[ib][i] - vpos[ia][i];
          e2[i] = vpos[ic][i] - vpos[ia][i];
        end
        shrink_edge(e1);
        shrink_edge(e2);
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        if (!unit_q14(cr, fn)) begin
          r.degen = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            nsum[ia][i] = clamp_sum(nsum[ia][i], fn[i]);
            nsum[ib][i] = clamp_sum(nsum[ib][i], fn[i]);
            nsum[ic][i] = clamp_sum(nsum[ic][i], fn[i]);
          end
        end
      end
      KIND_QUERY: begin
        if (!unit_q14(nsum[ia], nv)) r.degen = 1'b1;
      end
      default: ;
    endcase
    r.nx = nv[0][15:0];
    r.ny = nv[1][15:0];
    r.nz = nv[2][15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    normal_res_t got, want;
    if (rst) begin
      for (int v = 0; v < VERTEX_DEPTH_DEF; v++)
        for (int i = 0; i < 3; i++) begin
          vpos[v][i] = 0;
          nsum[v][i] = 0;
        end
      expected_normals.delete();
      errors <= 0;
      pending <= 0;
      n_results <= 0;
      n_flagged <= 0;
    end else begin
      // Compare first so a result in the same cycle never sees a newer request.
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0]};
        n_results <= n_results + 1;
        if (got.degen) n_flagged <= n_flagged + 1;
        if (expected_normals.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", got);
          errors <= errors + 1;
        end else begin
          want = expected_normals.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("mismatch: expected n=(%0d,%0d,%0d) deg=%0d got n=(%0d,%0d,%0d) deg=%0d",
                       want.nx, want.ny, want.nz, want.degen,
                       got.nx, got.ny, got.nz, got.degen);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_normals = {expected_normals, predict_normal(s_tuser, s_tdata)};
      pending <= expected_normals.size();
    end
  end

endmodule

// ----- tb/mesh_vertex_normal_accumulator_unit_test.sv -----
// Stimulus and verdict for the mesh vertex normal accumulator.
`timescale 1ns / 1ps
module mesh_vertex_normal_accumulator_unit_test;
  import mvna_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0]   s_tuser = 2'd0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic [0:0]   m_tuser;

  int  errors, pending, n_results, n_flagged;
  int  n_tri = 0, n_query = 0, n_write = 0;
  bit  hold_sink = 1'b0;
  bit  written [VERTEX_DEPTH_DEF];
  int  near_pool [8];

  always #5 clk = ~clk;

  mesh_vertex_normal_accumulator_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  mvna_scoreboard checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending), .n_results(n_results), .n_flagged(n_flagged)
  );

  // Receiver: stall on its own pattern; hold off completely while hold_sink is set.
  always @(posedge clk) begin
    int mode;
    mode = $urandom_range(0, 99);
    if (rst || hold_sink) m_tready <= 1'b0;
    else if (mode < 20) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // Send one request and wait for its handshake; valid stays high across back-to-back requests.
  task automatic send_request(kind_t k, int a, int b, int c,
                              logic [31:0] x, logic [31:0] y, logic [31:0] z);
    s_tuser  <= k;
    s_tdata  <= {2'b00, z, y, x, c[9:0], b[9:0], a[9:0]};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (k)
      KIND_WRITE: begin
        n_write++;
        written[a] = 1'b1;
      end
      KIND_TRI:   n_tri++;
      default:    n_query++;
    endcase
  endtask

  task automatic idle_sender(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [31:0] any_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 255) << 16;
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_written();
    int v;
    do v = $urandom_range(0, VERTEX_DEPTH_DEF - 1); while (!written[v]);
    return v;
  endfunction

  // Random mesh activity: triangles, writes and queries, often over a small live set.
  task automatic random_request();
    int sel, a, b, c;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, VERTEX_DEPTH_DEF - 1)
                                      : near_pool[$urandom_range(0, 7)];
      send_request(KIND_WRITE, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   any_coord(), any_coord(), any_coord());
    end else if (sel < 65) begin
      if ($urandom_range(0, 2) != 0) begin
        a = near_pool[$urandom_range(0, 7)];
        b = near_pool[$urandom_range(0, 7)];
        c = near_pool[$urandom_range(0, 7)];
      end else begin
        a = pick_written();
        b = pick_written();
        c = pick_written();
      end
      send_request(KIND_TRI, a, b, c, $urandom(), $urandom(), $urandom());
    end else if (sel < 97) begin
      a = ($urandom_range(0, 1) == 0) ? near_pool[$urandom_range(0, 7)] : pick_written();
      send_request(KIND_QUERY, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom(), $urandom(), $urandom());
    end else begin
      // Unused kind: the block drops it but still answers with zeros.
      s_tuser  <= 2'd3;
      s_tdata  <= {2'b00, 30'($urandom()), $urandom(), $urandom(), $urandom()};
      s_tvalid <= 1'b1;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
  endtask

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int burst;
    foreach (written[i]) written[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of position, degenerate shapes, every kind.
    send_request(KIND_WRITE, 0, 0, 0, 32'h0, 32'h0, 32'h0);
    send_request(KIND_WRITE, 1, 0, 0, 32'h0001_0000, 32'h0, 32'h0);
    send_request(KIND_WRITE, 2, 0, 0, 32'h0, 32'h0001_0000, 32'h0);
    send_request(KIND_WRITE, 1023, 1023, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(KIND_WRITE, 1022, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(KIND_WRITE, 1021, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    send_request(KIND_QUERY, 0, 0, 0, 32'h0, 32'h0, 32'h0);           // zero sum
    send_request(KIND_TRI, 0, 1, 2, 32'h0, 32'h0, 32'h0);
    send_request(KIND_TRI, 0, 2, 1, 32'h0, 32'h0, 32'h0);             // cancels
    send_request(KIND_QUERY, 1, 0, 0, 32'h0, 32'h0, 32'h0);
    send_request(KIND_TRI, 0, 0, 1, 32'h0, 32'h0, 32'h0);             // repeated corner
    send_request(KIND_TRI, 1023, 1022, 1021, 32'h0, 32'h0, 32'h0);    // wide edges
    send_request(KIND_TRI, 1022, 1021, 0, 32'h0, 32'h0, 32'h0);
    send_request(KIND_QUERY, 1021, 0, 0, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 6; i++) send_request(KIND_TRI, 0, 1, 2, 32'h0, 32'h0, 32'h0);
    send_request(KIND_QUERY, 0, 0, 0, 32'h0, 32'h0, 32'h0);
    send_request(KIND_QUERY, 1023, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Live set for random triangles; seed it so every entry has a position.
    for (int i = 0; i < 8; i++) begin
      near_pool[i] = $urandom_range(0, VERTEX_DEPTH_DEF - 1);
      send_request(KIND_WRITE, near_pool[i], 0, 0, any_coord(), any_coord(), any_coord());
    end

    // Pressure: hold the receiver off while requests pile up behind the queue.
    fork
      begin
        hold_sink = 1'b1;
        repeat (3000) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 12; i++) random_request();
    join

    // Random traffic in bursts with gaps; drain completely now and then.
    for (int n = 0; n < 1650; n += burst) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst; i++) random_request();
      if ($urandom_range(0, 19) == 0) begin
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        idle_sender($urandom_range(1, 200));
      end
      if ($urandom_range(0, 9) == 0)
        near_pool[$urandom_range(0, 7)] = pick_written();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d vertex writes, %0d triangles, %0d queries; %0d results, %0d flagged.",
             n_write, n_tri, n_query, n_results, n_flagged);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
